FILE: hdl/fccs_pkg.sv
// Shared types, codes and constants of the fragment clash and span check unit.
package fccs_pkg;

	// Field widths
	localparam int COORD_W = 20;
	localparam int DIST_W  = 2 * (COORD_W + 1);
	localparam int REG_W   = 32;
	localparam int POS_W   = 10;
	localparam int FPOS_W  = 8;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int IDX_W   = 2;
	localparam int PT_W    = 3 * COORD_W;

	// Default store depths
	localparam int CHAIN_DEPTH_DEF = 1024;
	localparam int FRAG_DEPTH_DEF  = 256;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FRAG   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_FIT  = 2'd0;
	localparam logic [STAT_W-1:0] ST_COLL = 2'd1;
	localparam logic [STAT_W-1:0] ST_GAP  = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_MIN_SEP  = 2'd0;
	localparam logic [IDX_W-1:0] REG_GAP_LOW  = 2'd1;
	localparam logic [IDX_W-1:0] REG_GAP_HIGH = 2'd2;

	// Register reset values (4.0^2 and 3.5^2 in Q16)
	localparam logic [REG_W-1:0] MIN_SEP_RST  = 32'd1048576;
	localparam logic [REG_W-1:0] GAP_LOW_RST  = 32'd802816;
	localparam logic [REG_W-1:0] GAP_HIGH_RST = 32'd1048576;

	// Commands from controller to datapath
	typedef struct packed {
		logic append;
		logic clear;
		logic load_pt;
		logic issue;
		logic frag_inc;
		logic emit;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic count_zero;
		logic fail_set;
		logic in_last;
		logic last_pt;
		logic sweep_last;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hdl/fccs_ctrl.sv
// Controller state machine: decodes items and sequences the chain sweep.
module fccs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [fccs_pkg::CMD_W-1:0] cmd,
	input  fccs_pkg::dp_status_t    dp_status,
	output fccs_pkg::ctrl_cmd_t     ctrl
);
	import fccs_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SWEEP = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_APPEND: ctrl.append = 1'b1;
						CMD_CLEAR:  ctrl.clear  = 1'b1;
						CMD_FRAG: begin
							ctrl.load_pt = 1'b1;
							if (!dp_status.fail_set && !dp_status.count_zero) begin
								state_d = S_SWEEP;
							end else if (dp_status.in_last) begin
								state_d = S_EMIT;
							end else begin
								ctrl.frag_inc = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_SWEEP: begin
				ctrl.issue = 1'b1;
				if (dp_status.sweep_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!dp_status.pipe_busy) begin
					if (dp_status.last_pt) begin
						state_d = S_EMIT;
					end else begin
						ctrl.frag_inc = 1'b1;
						state_d       = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				if (dp_status.out_free) begin
					ctrl.emit = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/fccs_datapath.sv
// Datapath: chain memory, distance pipeline, fragment tracking and result register.
module fccs_datapath #(
	parameter int CHAIN_DEPTH = fccs_pkg::CHAIN_DEPTH_DEF,
	parameter int FRAG_DEPTH  = fccs_pkg::FRAG_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fccs_pkg::ctrl_cmd_t         ctrl,
	output fccs_pkg::dp_status_t        dp_status,
	input  logic [fccs_pkg::COORD_W-1:0] px,
	input  logic [fccs_pkg::COORD_W-1:0] py,
	input  logic [fccs_pkg::COORD_W-1:0] pz,
	input  logic                        last,
	input  logic                        cfg_we,
	input  logic [fccs_pkg::IDX_W-1:0]  cfg_index,
	input  logic [fccs_pkg::REG_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fccs_pkg::STAT_W-1:0] status,
	output logic [fccs_pkg::DIST_W-1:0] max_dist_sq,
	output logic [fccs_pkg::POS_W-1:0]  coll_chain_pos,
	output logic [fccs_pkg::FPOS_W-1:0] coll_frag_pos
);
	import fccs_pkg::*;

	localparam int AW = $clog2(CHAIN_DEPTH);
	localparam int CW = $clog2(CHAIN_DEPTH + 1);
	localparam int FW = $clog2(FRAG_DEPTH);

	// Magnitude of a coordinate difference, exact in one extra bit
	function automatic logic [COORD_W:0] abs_diff(input logic [COORD_W-1:0] a,
	                                              input logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[COORD_W] ? (~d + 1'b1) : d;
	endfunction

	// Configuration registers
	logic [REG_W-1:0] min_sep_q, gap_low_q, gap_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sep_q  <= MIN_SEP_RST;
			gap_low_q  <= GAP_LOW_RST;
			gap_high_q <= GAP_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_SEP:  min_sep_q  <= cfg_data;
				REG_GAP_LOW:  gap_low_q  <= cfg_data;
				REG_GAP_HIGH: gap_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Chain count and sweep pointer
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic          full;
	logic          sweep_last;
	logic          is_join;

	assign full       = (count_q == CW'(CHAIN_DEPTH));
	assign sweep_last = ((CW'(ptr_q) + 1'b1) == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
		end else begin
			if (ctrl.clear) begin
				count_q <= '0;
			end else if (ctrl.append && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (ctrl.load_pt) begin
				ptr_q <= '0;
			end else if (ctrl.issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// Chain memory: one write port on append, one registered read on sweep
	logic [PT_W-1:0] chain_mem [CHAIN_DEPTH];
	logic [PT_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (ctrl.append && !full) begin
			chain_mem[count_q[AW-1:0]] <= {pz, py, px};
		end
		if (ctrl.issue) begin
			rdata_s1 <= chain_mem[ptr_q];
		end
	end

	// Fragment point held for the sweep
	logic [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
	logic               last_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_pt) begin
			pt_x_q <= px;
			pt_y_q <= py;
			pt_z_q <= pz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (ctrl.load_pt) begin
			last_q <= last;
		end
	end

	// Pipeline control bits
	logic valid_s1, valid_s2, valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ctrl.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Fragment tracking registers
	logic [FW-1:0]     frag_q;
	logic [DIST_W-1:0] max_seen_q;
	logic [STAT_W-1:0] fail_q;
	logic [POS_W-1:0]  fail_chain_q;
	logic [FPOS_W-1:0] fail_frag_q;

	// Join pair: first fragment point against the last chain point
	assign is_join = (frag_q == '0) && sweep_last;

	// Pipeline payload: squares, then sum
	logic [AW-1:0]     pos_s1, pos_s2, pos_s3;
	logic              join_s1, join_s2, join_s3;
	logic [DIST_W-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [DIST_W-1:0] sum_s3;
	logic [COORD_W:0]  ax, ay, az;

	always_comb begin
		ax = abs_diff(pt_x_q, rdata_s1[COORD_W-1:0]);
		ay = abs_diff(pt_y_q, rdata_s1[2*COORD_W-1:COORD_W]);
		az = abs_diff(pt_z_q, rdata_s1[3*COORD_W-1:2*COORD_W]);
	end

	always_ff @(posedge clk) begin
		pos_s1  <= ptr_q;
		join_s1 <= is_join;
		pos_s2  <= pos_s1;
		join_s2 <= join_s1;
		sq_x_s2 <= DIST_W'(ax) * DIST_W'(ax);
		sq_y_s2 <= DIST_W'(ay) * DIST_W'(ay);
		sq_z_s2 <= DIST_W'(az) * DIST_W'(az);
		pos_s3  <= pos_s2;
		join_s3 <= join_s2;
		sum_s3  <= sq_x_s2 + sq_y_s2 + sq_z_s2;
	end

	// Pair evaluation; pairs after the first failure are ignored
	logic eval;
	assign eval = valid_s3 && (fail_q == ST_FIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_q       <= '0;
			max_seen_q   <= '0;
			fail_q       <= ST_FIT;
			fail_chain_q <= '0;
			fail_frag_q  <= '0;
		end else if (ctrl.clear || ctrl.emit) begin
			frag_q       <= '0;
			max_seen_q   <= '0;
			fail_q       <= ST_FIT;
			fail_chain_q <= '0;
			fail_frag_q  <= '0;
		end else begin
			if (ctrl.frag_inc && (frag_q < FW'(FRAG_DEPTH - 1))) begin
				frag_q <= frag_q + 1'b1;
			end
			if (eval) begin
				if (sum_s3 > max_seen_q) begin
					max_seen_q <= sum_s3;
				end
				if (join_s3) begin
					if ((sum_s3 < DIST_W'(gap_low_q)) || (sum_s3 > DIST_W'(gap_high_q))) begin
						fail_q <= ST_GAP;
					end
				end else if (sum_s3 < DIST_W'(min_sep_q)) begin
					fail_q       <= ST_COLL;
					fail_chain_q <= POS_W'(pos_s3);
					fail_frag_q  <= FPOS_W'(frag_q);
				end
			end
		end
	end

	// Result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			status         <= fail_q;
			max_dist_sq    <= (fail_q == ST_FIT) ? max_seen_q : '0;
			coll_chain_pos <= (fail_q == ST_COLL) ? fail_chain_q : '0;
			coll_frag_pos  <= (fail_q == ST_COLL) ? fail_frag_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	// Status to controller
	always_comb begin
		dp_status            = '0;
		dp_status.count_zero = (count_q == '0);
		dp_status.fail_set   = (fail_q != ST_FIT);
		dp_status.in_last    = last;
		dp_status.last_pt    = last_q;
		dp_status.sweep_last = sweep_last;
		dp_status.pipe_busy  = valid_s1 || valid_s2 || valid_s3;
		dp_status.out_free   = !out_valid_q || !out_stall;
	end

endmodule

FILE: hdl/fragment_clash_and_span_check_unit.sv
// Fragment clash and span check: chain point store with squared-distance sweep.
// Append, clear and unused commands are taken without stalling the input; a point after a
// failure or against an empty chain skips the sweep, and when last it passes the emit state.
// A swept point stalls the input through the sweep and drain states, and the emit state when
// last; its result is registered on emit, and a stalled result register holds the emit state.
// Reset clears control state and loads register defaults; the chain memory is not cleared.
module fragment_clash_and_span_check_unit #(
	parameter int CHAIN_DEPTH = fccs_pkg::CHAIN_DEPTH_DEF,
	parameter int FRAG_DEPTH  = fccs_pkg::FRAG_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [fccs_pkg::CMD_W-1:0]   cmd,
	input  logic [fccs_pkg::COORD_W-1:0] px,
	input  logic [fccs_pkg::COORD_W-1:0] py,
	input  logic [fccs_pkg::COORD_W-1:0] pz,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fccs_pkg::STAT_W-1:0]  status,
	output logic [fccs_pkg::DIST_W-1:0]  max_dist_sq,
	output logic [fccs_pkg::POS_W-1:0]   coll_chain_pos,
	output logic [fccs_pkg::FPOS_W-1:0]  coll_frag_pos,
	input  logic                         cfg_we,
	input  logic [fccs_pkg::IDX_W-1:0]   cfg_index,
	input  logic [fccs_pkg::REG_W-1:0]   cfg_data
);
	import fccs_pkg::*;

	ctrl_cmd_t  ctrl;
	dp_status_t dp_status;

	fccs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.dp_status (dp_status),
		.ctrl      (ctrl)
	);

	fccs_datapath #(
		.CHAIN_DEPTH (CHAIN_DEPTH),
		.FRAG_DEPTH  (FRAG_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.dp_status      (dp_status),
		.px             (px),
		.py             (py),
		.pz             (pz),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.max_dist_sq    (max_dist_sq),
		.coll_chain_pos (coll_chain_pos),
		.coll_frag_pos  (coll_frag_pos)
	);

endmodule
